FILE: rtl/fpa_pkg.sv
// Shared types and codes for the Q24.8 fixed-point ALU.
package fpa_pkg;

   typedef enum logic [3:0] {
      MODE_ADD      = 4'd0,
      MODE_SUB      = 4'd1,
      MODE_MUL      = 4'd2,
      MODE_DIV      = 4'd3,
      MODE_MIN      = 4'd4,
      MODE_MAX      = 4'd5,
      MODE_COMPARE  = 4'd6,
      MODE_INC      = 4'd7,
      MODE_DEC      = 4'd8,
      MODE_FROM_INT = 4'd9,
      MODE_TO_INT   = 4'd10
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK   = 2'd0,
      STATUS_OVF  = 2'd1,
      STATUS_DIV0 = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      KIND_PLAIN = 2'd0,
      KIND_MUL   = 2'd1,
      KIND_DIV   = 2'd2
   } kind_type;

   // Side data that travels with each transaction down the divider chain
   typedef struct packed {
      kind_type    kind;
      logic        neg;
      logic [31:0] res;
      logic        gt;
      logic        lt;
      logic        eq;
      status_type  status;
      logic [63:0] prod;
   } info_type;

endpackage

FILE: rtl/fpa_front.sv
// Operand stage: decodes the mode, finishes the plain operations and seeds the divider.
module fpa_front
   import fpa_pkg::*;
#(
   parameter int FRAC_BITS = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    adv,
   input  logic                    valid,
   input  logic [3:0]              mode,
   input  logic signed [31:0]      operand_a,
   input  logic signed [31:0]      operand_b,
   output logic                    valid_out,
   output info_type                info_out,
   output logic [31:0]             rem_out,
   output logic [32+FRAC_BITS-1:0] rq_out,
   output logic [31:0]             d_out
);

   localparam int DW = 32 + FRAC_BITS;

   logic                 valid_ff;
   info_type             info_ff, info_in;
   logic [DW-1:0]        rq_ff, rq_in;
   logic [31:0]          d_ff, d_in;
   logic signed [32:0]   sum;
   logic signed [32:0]   addend;
   logic                 sub_op;
   logic [31:0]          mag_a;
   logic [FRAC_BITS:0]   top_a;

   always_comb begin
      mag_a  = operand_a[31] ? 32'(-operand_a) : operand_a;
      top_a  = operand_a[31:31-FRAC_BITS];
      sub_op = (mode == MODE_SUB) || (mode == MODE_DEC);
      addend = ((mode == MODE_INC) || (mode == MODE_DEC)) ? 33'sd1 : 33'(operand_b);
      sum    = sub_op ? (33'(operand_a) - addend) : (33'(operand_a) + addend);

      info_in        = '0;
      info_in.kind   = KIND_PLAIN;
      info_in.status = STATUS_OK;
      info_in.prod   = 64'(operand_a) * 64'(operand_b);
      info_in.neg    = operand_a[31] ^ operand_b[31];
      rq_in          = {mag_a, {FRAC_BITS{1'b0}}};
      d_in           = operand_b[31] ? 32'(-operand_b) : operand_b;

      case (mode)
         MODE_ADD, MODE_SUB, MODE_INC, MODE_DEC: begin
            info_in.res = sum[31:0];
            if (sum[32] != sum[31]) info_in.status = STATUS_OVF;
         end
         MODE_MUL: info_in.kind = KIND_MUL;
         MODE_DIV: begin
            if (operand_b == 32'sd0) info_in.status = STATUS_DIV0;
            else info_in.kind = KIND_DIV;
         end
         MODE_MIN: info_in.res = (operand_a > operand_b) ? operand_b : operand_a;
         MODE_MAX: info_in.res = (operand_a > operand_b) ? operand_a : operand_b;
         MODE_COMPARE: begin
            info_in.gt = operand_a > operand_b;
            info_in.lt = operand_a < operand_b;
            info_in.eq = operand_a == operand_b;
         end
         MODE_FROM_INT: begin
            info_in.res = operand_a <<< FRAC_BITS;
            if (!((top_a == '0) || (&top_a))) info_in.status = STATUS_OVF;
         end
         MODE_TO_INT: info_in.res = operand_a >>> FRAC_BITS;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= valid;
      end
      if (adv) begin
         info_ff <= info_in;
         rq_ff   <= rq_in;
         d_ff    <= d_in;
      end
   end

   assign valid_out = valid_ff;
   assign info_out  = info_ff;
   assign rem_out   = '0;
   assign rq_out    = rq_ff;
   assign d_out     = d_ff;

endmodule

FILE: rtl/fpa_div_cell.sv
// One restoring-division cell: settles one quotient bit and passes the transaction on.
module fpa_div_cell
   import fpa_pkg::*;
#(
   parameter int FRAC_BITS = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    adv,
   input  logic                    valid_in,
   input  info_type                info_in,
   input  logic [31:0]             rem_in,
   input  logic [32+FRAC_BITS-1:0] rq_in,
   input  logic [31:0]             d_in,
   output logic                    valid_out,
   output info_type                info_out,
   output logic [31:0]             rem_out,
   output logic [32+FRAC_BITS-1:0] rq_out,
   output logic [31:0]             d_out
);

   localparam int DW = 32 + FRAC_BITS;

   logic          valid_ff;
   info_type      info_ff;
   logic [31:0]   rem_ff, rem_nx_in;
   logic [DW-1:0] rq_ff, rq_nx_in;
   logic [31:0]   d_ff;
   logic [32:0]   trial;
   logic          ge;

   always_comb begin
      // bring down the next dividend bit, shift the quotient bit in at the bottom
      trial     = {rem_in, rq_in[DW-1]};
      ge        = trial >= {1'b0, d_in};
      rem_nx_in = ge ? 32'(trial - {1'b0, d_in}) : trial[31:0];
      rq_nx_in  = {rq_in[DW-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= valid_in;
      end
      if (adv) begin
         info_ff <= info_in;
         rem_ff  <= rem_nx_in;
         rq_ff   <= rq_nx_in;
         d_ff    <= d_in;
      end
   end

   assign valid_out = valid_ff;
   assign info_out  = info_ff;
   assign rem_out   = rem_ff;
   assign rq_out    = rq_ff;
   assign d_out     = d_ff;

endmodule

FILE: rtl/fixed_point_alu_q24_8_unit.sv
// Top level of the pipelined signed fixed-point ALU.
// Usage:
//   Send one operation per transaction on the req_ channel: mode, operand_a and
//   operand_b packed in req_tdata. One result per operation comes back on the
//   rsp_ channel, in order: result, compare flags and status in rsp_tdata.
// Pipeline: from acceptance to rsp_tvalid, for every mode, one operand stage,
//   32 + FRAC_BITS divider cells and one output register.
// Throughput: one operation per cycle unless stalled; the divider chain settles
//   one quotient bit per cell, so every mode shares the same pipeline timing.
// Stall: when rsp_tready is low while a result is held, the whole pipeline
//   holds and req_tready drops in the same cycle; bubbles in the pipeline
//   still advance whenever the output register is empty or being taken.
// Reset: synchronous, active high; clears every stage valid, so no result is
//   presented afterwards until new operations arrive.
// Division by zero gives a zero result with status 2; overflow wraps with status 1.
module fixed_point_alu_q24_8_unit
   import fpa_pkg::*;
#(
   parameter int FRAC_BITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // mode[3:0], operand_a[35:4], operand_b[67:36], zero fill [71:68]
   input  logic [71:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // result[31:0], a_greater[32], a_less[33], a_equal[34], status[36:35], zero fill [39:37]
   output logic [39:0] rsp_tdata
);

   localparam int DW    = 32 + FRAC_BITS;
   localparam int CELLS = DW;

   logic              adv;
   logic              valid_c [CELLS+1];
   info_type          info_c  [CELLS+1];
   logic [31:0]       rem_c   [CELLS+1];
   logic [DW-1:0]     rq_c    [CELLS+1];
   logic [31:0]       d_c     [CELLS+1];

   logic              rsp_valid_ff;
   logic [39:0]       rsp_data_ff, rsp_data_in;
   info_type          fin;
   logic [DW-1:0]     quo, quo_signed;
   logic signed [63:0] mul_sh;
   logic [31:0]       res_fin;
   status_type        status_fin;

   assign adv        = !rsp_valid_ff || rsp_tready;
   assign req_tready = adv;

   fpa_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .valid     (req_tvalid),
      .mode      (req_tdata[3:0]),
      .operand_a (req_tdata[35:4]),
      .operand_b (req_tdata[67:36]),
      .valid_out (valid_c[0]),
      .info_out  (info_c[0]),
      .rem_out   (rem_c[0]),
      .rq_out    (rq_c[0]),
      .d_out     (d_c[0])
   );

   for (genvar i = 0; i < CELLS; i++) begin : g_cell
      fpa_div_cell #(.FRAC_BITS(FRAC_BITS)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .valid_in  (valid_c[i]),
         .info_in   (info_c[i]),
         .rem_in    (rem_c[i]),
         .rq_in     (rq_c[i]),
         .d_in      (d_c[i]),
         .valid_out (valid_c[i+1]),
         .info_out  (info_c[i+1]),
         .rem_out   (rem_c[i+1]),
         .rq_out    (rq_c[i+1]),
         .d_out     (d_c[i+1])
      );
   end

   always_comb begin
      fin        = info_c[CELLS];
      quo        = rq_c[CELLS];
      quo_signed = fin.neg ? DW'(-quo) : quo;
      mul_sh     = $signed(fin.prod) >>> FRAC_BITS;
      res_fin    = fin.res;
      status_fin = fin.status;
      case (fin.kind)
         KIND_MUL: begin
            res_fin = mul_sh[31:0];
            if (!((mul_sh[63:31] == '0) || (&mul_sh[63:31]))) status_fin = STATUS_OVF;
         end
         KIND_DIV: begin
            res_fin = quo_signed[31:0];
            // a negative quotient may reach magnitude 2^31, a positive one may not
            if (fin.neg) begin
               if ((quo[DW-1:32] != '0) || (quo[31] && (quo[30:0] != '0)))
                  status_fin = STATUS_OVF;
            end else if (quo[DW-1:31] != '0) begin
               status_fin = STATUS_OVF;
            end
         end
         default: ;
      endcase
      rsp_data_in = {3'b000, status_fin, fin.eq, fin.lt, fin.gt, res_fin};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= valid_c[CELLS];
      end
      if (adv) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

FILE: dv/fixed_point_alu_q24_8_checker.sv
// Result predictor and scoreboard for the fixed-point ALU.
`timescale 1ns / 1ps
module fixed_point_alu_q24_8_checker
   import fpa_pkg::*;
#(
   parameter int FRAC_BITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [71:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,
   output int          errors,
   output int          pending
);

   typedef struct packed {
      logic [31:0] result;
      logic        gt;
      logic        lt;
      logic        eq;
      status_type  status;
   } alu_answer_type;

   alu_answer_type answers_due[$];

   function automatic logic [31:0] wrap_value(input logic signed [95:0] v,
                                              inout status_type st);
      if (v > 96'sd2147483647 || v < -96'sd2147483648) st = STATUS_OVF;
      return v[31:0];
   endfunction

   function automatic alu_answer_type alu_predict(input logic [3:0] mode,
                                                  input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
      alu_answer_type r;
      logic signed [95:0] wa, wb, q;
      logic [95:0] na, nb;
      r = '0;
      r.status = STATUS_OK;
      wa = a;
      wb = b;
      case (mode)
         MODE_ADD:      r.result = wrap_value(wa + wb, r.status);
         MODE_SUB:      r.result = wrap_value(wa - wb, r.status);
         MODE_MUL:      r.result = wrap_value((wa * wb) >>> FRAC_BITS, r.status);
         MODE_DIV: begin
            if (b == 0) r.status = STATUS_DIV0;
            else begin
               na = (wa < 0 ? -wa : wa) << FRAC_BITS;
               nb = wb < 0 ? -wb : wb;
               q = na / nb;
               if ((a < 0) != (b < 0)) q = -q;
               r.result = wrap_value(q, r.status);
            end
         end
         MODE_MIN:      r.result = (a > b) ? b : a;
         MODE_MAX:      r.result = (a > b) ? a : b;
         MODE_COMPARE: begin
            r.gt = a > b;
            r.lt = a < b;
            r.eq = a == b;
         end
         MODE_INC:      r.result = wrap_value(wa + 1, r.status);
         MODE_DEC:      r.result = wrap_value(wa - 1, r.status);
         MODE_FROM_INT: r.result = wrap_value(wa <<< FRAC_BITS, r.status);
         MODE_TO_INT:   r.result = a >>> FRAC_BITS;
         default: ;
      endcase
      return r;
   endfunction

   assign pending = answers_due.size();

   always @(posedge clock) begin
      alu_answer_type want;
      int bad;
      bad = 0;
      if (reset) begin
         errors <= 0;
         answers_due.delete();
      end else begin
         if (req_tvalid && req_tready)
            answers_due.push_back(alu_predict(req_tdata[3:0], req_tdata[35:4],
                                              req_tdata[67:36]));
         if (rsp_tvalid && rsp_tready) begin
            if (answers_due.size() == 0) begin
               $error("result with nothing outstanding: %h", rsp_tdata);
               bad++;
            end else begin
               want = answers_due.pop_front();
               if (rsp_tdata[31:0] !== want.result) begin
                  $error("result: expected %h, got %h", want.result, rsp_tdata[31:0]);
                  bad++;
               end
               if (rsp_tdata[32] !== want.gt) begin
                  $error("a_greater: expected %b, got %b", want.gt, rsp_tdata[32]);
                  bad++;
               end
               if (rsp_tdata[33] !== want.lt) begin
                  $error("a_less: expected %b, got %b", want.lt, rsp_tdata[33]);
                  bad++;
               end
               if (rsp_tdata[34] !== want.eq) begin
                  $error("a_equal: expected %b, got %b", want.eq, rsp_tdata[34]);
                  bad++;
               end
               if (rsp_tdata[36:35] !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_tdata[36:35]);
                  bad++;
               end
            end
         end
         if (bad != 0) errors <= errors + bad;
      end
   end

endmodule

FILE: dv/fixed_point_alu_q24_8_unit_test.sv
// Stimulus and verdict for the fixed-point ALU testbench.
`timescale 1ns / 1ps
module fixed_point_alu_q24_8_unit_test
   import fpa_pkg::*;
();

   localparam int FRAC_BITS = 8;
   localparam int LATENCY = FRAC_BITS + 34;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [71:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   int          errors;
   int          pending;
   int          send_idle = 0;
   int          sink_stall = 0;
   bit          hold_off = 1'b0;

   fixed_point_alu_q24_8_unit #(.FRAC_BITS(FRAC_BITS)) uut (.*);

   fixed_point_alu_q24_8_checker #(.FRAC_BITS(FRAC_BITS)) scoreboard (.*);

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("fixed_point_alu_q24_8_unit_test NOT OK");
      $finish;
   end

   // Sink: random stalls, or a long hold-off while hold_off is set
   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= !hold_off && ($urandom_range(99) >= sink_stall);
   end

   function automatic logic [31:0] pick_operand();
      case ($urandom_range(7))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'($signed($urandom_range(4096)) - 2048);
         3: return {$urandom_range(1) ? 24'hffffff : 24'h0, 8'($urandom)};
         4: return 32'($urandom_range(3)) << $urandom_range(31);
         default: return $urandom;
      endcase
   endfunction

   // Offer one operation and hold it until taken; valid stays up for the next one
   task automatic offer_op(input logic [3:0] mode, input logic [31:0] a,
                           input logic [31:0] b);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'h0, b, a, mode};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic drain();
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   initial begin
      logic [31:0] edge_vals[6];
      int n;
      edge_vals = '{32'h0, 32'h1, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000,
                    32'h0000_0100};
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: every mode at the extremes, divide by zero, unused modes
      for (int m = 0; m <= 10; m++)
         offer_op(4'(m), edge_vals[m % 6], edge_vals[(m + 3) % 6]);
      offer_op(MODE_DIV, 32'h0000_0500, 32'h0);
      offer_op(MODE_DIV, 32'h8000_0000, 32'hffff_ffff);
      offer_op(MODE_MUL, 32'h8000_0000, 32'h8000_0000);
      offer_op(MODE_MUL, 32'hffff_ffff, 32'h0000_0001);
      offer_op(MODE_COMPARE, 32'h1234, 32'h1234);
      offer_op(MODE_COMPARE, 32'h8000_0000, 32'h7fff_ffff);
      offer_op(MODE_INC, 32'h7fff_ffff, 32'h0);
      offer_op(MODE_DEC, 32'h8000_0000, 32'h0);
      offer_op(MODE_TO_INT, 32'hffff_ff01, 32'h0);
      offer_op(MODE_FROM_INT, 32'hff80_0000, 32'h0);
      offer_op(4'd11, 32'h5, 32'h3);
      offer_op(4'd15, 32'hffff_ffff, 32'hffff_ffff);
      // Pause until every result is back
      req_tvalid <= 1'b0;
      drain();

      // Long receiver hold-off while operations keep coming
      hold_off = 1'b1;
      fork
         begin
            repeat (3 * LATENCY) @(posedge clock);
            hold_off = 1'b0;
         end
         for (int i = 0; i < 80; i++)
            offer_op(4'($urandom_range(10)), pick_operand(), pick_operand());
      join

      // Random phases: none, sender idle, receiver stall, both
      for (int phase = 0; phase < 4; phase++) begin
         send_idle  = (phase == 1) ? 85 : (phase == 3) ? 36 : 0;
         sink_stall = (phase == 2) ? 85 : (phase == 3) ? 36 : 0;
         n = (phase == 0) ? 100 : 75;
         for (int i = 0; i < n; i++)
            offer_op($urandom_range(99) < 95 ? 4'($urandom_range(10)) : 4'($urandom),
                     pick_operand(), pick_operand());
      end
      req_tvalid <= 1'b0;
      send_idle = 0;
      sink_stall = 0;
      drain();
      repeat (LATENCY + 10) @(posedge clock);
      if (errors == 0 && pending == 0)
         $display("fixed_point_alu_q24_8_unit_test OK");
      else
         $display("fixed_point_alu_q24_8_unit_test NOT OK");
      $finish;
   end

endmodule
